[design/npcm_pkg.sv]
// Package for the nearest palette color mapper.
// Holds widths, operation codes and the structs passed between the scan modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = 8;
    localparam int COUNT_W       = 9;

    // Payload widths
    localparam int COLOR_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int SQ_W     = 16;
    localparam int DIST_W   = 18;

    // Longest scan: bounded by the depth and by what an 8-bit slot can address
    localparam logic [COUNT_W-1:0] SCAN_MAX = COUNT_W'(PALETTE_DEPTH);

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // Tag that travels alongside a palette read
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] idx;
    } rd_tag_t;

    // Registered output of the distance unit: per-channel squared differences
    typedef struct packed {
        logic                           vld;
        logic [ADDR_W-1:0]              idx;
        logic [COLOR_W-1:0]             color;
        logic [NUM_CHAN-1:0][SQ_W-1:0]  sq;
    } dist_res_t;

endpackage

`default_nettype wire

[design/nearest_palette_color_mapper_top.sv]
// Top level of the nearest palette color mapper: scan sequencer, best-match
// tracking and result register. Depends on npcm_pkg, npcm_palette, npcm_dist_unit.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, operation, entry_index,     | in
//          | pixel_color                                     |
//  out     | out_valid, out_ready, mapped_color, match_index,| out
//          | match_distance, matched                         |
//  cfg     | cfg_we, cfg_wdata (palette_count)               | in
//
// A load is written to the palette in its transfer cycle.
// A map reads min(palette_count, 256) entries, one palette entry per cycle through
// the single read port; the two pipeline stages drain, ST_SCAN closes the scan and
// ST_FIN loads the result register once it is free.
// in_ready is low while a map scans and while a result waits for an output slot.
// The result register holds one finished item; new transfers are still taken while it waits.
// Reset clears control state and palette_count; palette contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_mapper_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [7:0]                   entry_index,
    input  wire logic [npcm_pkg::COLOR_W-1:0] pixel_color,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [npcm_pkg::COLOR_W-1:0] mapped_color,
    output logic      [7:0]                   match_index,
    output logic      [npcm_pkg::DIST_W-1:0]  match_distance,
    output logic                              matched,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [npcm_pkg::COUNT_W-1:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [npcm_pkg::COUNT_W-1:0]       count_reg;
    logic [npcm_pkg::COUNT_W-1:0]       limit_reg;
    logic [npcm_pkg::COUNT_W-1:0]       iss_cnt_reg;
    logic [npcm_pkg::COLOR_W-1:0]       pix_reg;
    npcm_pkg::rd_tag_t                  rd_tag_reg;
    npcm_pkg::rd_tag_t                  rd_tag_next;

    logic                               found_reg;
    logic [npcm_pkg::COLOR_W-1:0]       best_color_reg;
    logic [npcm_pkg::ADDR_W-1:0]        best_idx_reg;
    logic [npcm_pkg::DIST_W-1:0]        best_dist_reg;

    logic                               out_valid_reg;
    logic [npcm_pkg::COLOR_W-1:0]       out_color_reg;
    logic [npcm_pkg::ADDR_W-1:0]        out_idx_reg;
    logic [npcm_pkg::DIST_W-1:0]        out_dist_reg;
    logic                               out_matched_reg;

    logic                               accept;
    logic                               accept_map;
    logic                               issue;
    logic                               scan_done;
    logic                               out_free;
    logic                               fin_load;
    logic                               better;
    logic [npcm_pkg::DIST_W-1:0]        dist_sum;
    logic [npcm_pkg::COUNT_W-1:0]       limit_next;
    logic [npcm_pkg::COLOR_W-1:0]       rd_data;
    npcm_pkg::dist_res_t                dist_res;

    // Handshake
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign accept_map = accept && (operation == npcm_pkg::OP_MAP);
    assign out_free   = !out_valid_reg || out_ready;
    assign fin_load   = (state_reg == ST_FIN) && out_free;

    // Scan length clamp
    assign limit_next = (count_reg > npcm_pkg::SCAN_MAX) ? npcm_pkg::SCAN_MAX : count_reg;

    // Read issue and pipeline drain detection
    assign issue     = (state_reg == ST_SCAN) && (iss_cnt_reg != limit_reg);
    assign scan_done = (state_reg == ST_SCAN) && (iss_cnt_reg == limit_reg)
                       && !rd_tag_reg.vld && !dist_res.vld;

    assign rd_tag_next.vld = issue;
    assign rd_tag_next.idx = iss_cnt_reg[npcm_pkg::ADDR_W-1:0];

    npcm_palette u_palette (
        .clk   (clk),
        .we    (accept && (operation == npcm_pkg::OP_LOAD)),
        .waddr (entry_index),
        .wdata (pixel_color),
        .re    (issue),
        .raddr (rd_tag_next.idx),
        .rdata (rd_data)
    );

    npcm_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pix_reg),
        .entry   (rd_data),
        .tag_in  (rd_tag_reg),
        .res_out (dist_res)
    );

    // Sum of squares and strict compare against the running best
    assign dist_sum = npcm_pkg::DIST_W'(dist_res.sq[0]) + npcm_pkg::DIST_W'(dist_res.sq[1])
                    + npcm_pkg::DIST_W'(dist_res.sq[2]) + npcm_pkg::DIST_W'(dist_res.sq[3]);
    assign better   = dist_res.vld && (!found_reg || (dist_sum < best_dist_reg));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_map)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            iss_cnt_reg    <= '0;
            limit_reg      <= '0;
            rd_tag_reg.vld <= 1'b0;
            rd_tag_reg.idx <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_tag_reg.vld <= rd_tag_next.vld;
            rd_tag_reg.idx <= rd_tag_next.idx;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (accept_map)
            begin
                limit_reg   <= limit_next;
                iss_cnt_reg <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_map)
        begin
            pix_reg        <= pixel_color;
            best_color_reg <= pixel_color;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
        end
        else if (better)
        begin
            best_color_reg <= dist_res.color;
            best_idx_reg   <= dist_res.idx;
            best_dist_reg  <= dist_sum;
        end
        if (fin_load)
        begin
            out_color_reg   <= best_color_reg;
            out_idx_reg     <= best_idx_reg;
            out_dist_reg    <= best_dist_reg;
            out_matched_reg <= found_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mapped_color   = out_color_reg;
    assign match_index    = out_idx_reg;
    assign match_distance = out_dist_reg;
    assign matched        = out_matched_reg;

`ifndef SYNTHESIS
    // Issue counter never runs past the clamped scan length
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_cnt_reg <= limit_reg) && (limit_reg <= npcm_pkg::SCAN_MAX))
        else $error("issue counter beyond scan length");

    // Distance results only arrive while a scan is running
    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_res.vld |-> (state_reg == ST_SCAN))
        else $error("distance result outside scan");

    // A load transfer never starts a scan
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == npcm_pkg::OP_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load started a scan");

    // A finished map with no match reports zero slot and zero distance
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !out_matched_reg |-> (out_idx_reg == '0) && (out_dist_reg == '0))
        else $error("unmatched result with nonzero slot or distance");

    // A scan over a nonempty palette always ends with a match
    a_found_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done && (limit_reg != '0) |-> found_reg)
        else $error("scan ended without a match");
`endif

endmodule

`default_nettype wire

[design/npcm_palette.sv]
// Palette store: 256 x 32 memory, one write port and one registered read port.
// Depends on npcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npcm_palette (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [npcm_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [npcm_pkg::COLOR_W-1:0] wdata,
    input  wire logic                         re,
    input  wire logic [npcm_pkg::ADDR_W-1:0]  raddr,
    output logic      [npcm_pkg::COLOR_W-1:0] rdata
);

    logic [npcm_pkg::COLOR_W-1:0] mem [npcm_pkg::PALETTE_DEPTH];
    logic [npcm_pkg::COLOR_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/npcm_dist_unit.sv]
// Shared distance unit: per-channel absolute difference and square, registered.
// Depends on npcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npcm_dist_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [npcm_pkg::COLOR_W-1:0] pixel,
    input  wire logic [npcm_pkg::COLOR_W-1:0] entry,
    input  wire npcm_pkg::rd_tag_t            tag_in,
    output npcm_pkg::dist_res_t               res_out
);

    logic                                            vld_reg;
    logic [npcm_pkg::ADDR_W-1:0]                     idx_reg;
    logic [npcm_pkg::COLOR_W-1:0]                    color_reg;
    logic [npcm_pkg::NUM_CHAN-1:0][npcm_pkg::SQ_W-1:0] sq_reg;
    logic [npcm_pkg::NUM_CHAN-1:0][npcm_pkg::SQ_W-1:0] sq_next;

    // One 8x8 square per channel, channels independent
    always_comb
    begin
        logic [npcm_pkg::CHAN_W-1:0] a;
        logic [npcm_pkg::CHAN_W-1:0] b;
        logic [npcm_pkg::CHAN_W-1:0] d;
        for (int c = 0; c < npcm_pkg::NUM_CHAN; c++)
        begin
            a = pixel[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W];
            b = entry[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            sq_next[c] = npcm_pkg::SQ_W'(d) * npcm_pkg::SQ_W'(d);
        end
    end

    // Valid is control, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tag_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= tag_in.idx;
        color_reg <= entry;
        sq_reg    <= sq_next;
    end

    assign res_out.vld   = vld_reg;
    assign res_out.idx   = idx_reg;
    assign res_out.color = color_reg;
    assign res_out.sq    = sq_reg;

endmodule

`default_nettype wire

[bench/nearest_palette_color_mapper_top_tb.sv]
// Self-checking bench for nearest_palette_color_mapper_top: palette loads and pixel
// maps with random idling on both channels, checked against an in-bench nearest-entry
// predictor. Depends on npcm_pkg and the design sources.
`timescale 1ns / 1ps

module nearest_palette_color_mapper_top_tb;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 280;   // longest scan plus margin
    localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
    localparam int TARGET_ITEMS = 1900;
    localparam int CALM_ITEMS   = 1700;  // past this point nobody idles

    typedef struct packed {
        logic                         op;
        logic [npcm_pkg::ADDR_W-1:0]  slot;
        logic [npcm_pkg::COLOR_W-1:0] color;
    } pixel_item_t;

    typedef struct packed {
        logic [npcm_pkg::COLOR_W-1:0] color;
        logic [7:0]                   index;
        logic [npcm_pkg::DIST_W-1:0]  sq_dist;
        logic                         hit;
    } match_t;

    // DUT ports
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic                          operation   = npcm_pkg::OP_LOAD;
    logic [7:0]                    entry_index = '0;
    logic [npcm_pkg::COLOR_W-1:0]  pixel_color = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic [npcm_pkg::COLOR_W-1:0]  mapped_color;
    logic [7:0]                    match_index;
    logic [npcm_pkg::DIST_W-1:0]   match_distance;
    logic                          matched;
    logic                          cfg_we      = 1'b0;
    logic [npcm_pkg::COUNT_W-1:0]  cfg_wdata   = '0;

    // Stimulus and prediction state
    pixel_item_t                   pixel_items[$];
    match_t                        expected_matches[$];
    pixel_item_t                   next_item;
    logic [npcm_pkg::COLOR_W-1:0]  shadow_palette [npcm_pkg::PALETTE_DEPTH];
    logic [npcm_pkg::COLOR_W-1:0]  gen_palette [npcm_pkg::PALETTE_DEPTH];
    int unsigned                   shadow_count   = 0;
    int unsigned                   pushed_items   = 0;
    int unsigned                   accepted_items = 0;
    int unsigned                   loads_taken    = 0;
    int unsigned                   maps_taken     = 0;
    int unsigned                   results_seen   = 0;
    int unsigned                   count_writes   = 0;
    int unsigned                   failures       = 0;
    int unsigned                   send_odds      = 0;  // percent chance of a sender idle burst
    int unsigned                   recv_odds      = 0;  // percent chance of a receiver stall
    int unsigned                   send_gap       = 0;
    int unsigned                   recv_gap       = 0;
    int unsigned                   quiet_cycles   = 0;
    match_t                        want;
    match_t                        got;

    nearest_palette_color_mapper_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .entry_index    (entry_index),
        .pixel_color    (pixel_color),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mapped_color   (mapped_color),
        .match_index    (match_index),
        .match_distance (match_distance),
        .matched        (matched),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Squared RGBA distance between two packed colors
    function automatic int unsigned rgba_distance(input logic [npcm_pkg::COLOR_W-1:0] a,
                                                  input logic [npcm_pkg::COLOR_W-1:0] b);
        int unsigned sum;
        int          d;
        sum = 0;
        for (int c = 0; c < npcm_pkg::NUM_CHAN; c++)
        begin
            d   = int'(a[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W])
                - int'(b[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W]);
            sum = sum + d * d;
        end
        return sum;
    endfunction

    // Nearest entry among the active slots; first strictly smaller distance wins
    function automatic match_t nearest_entry(input logic [npcm_pkg::COLOR_W-1:0] pixel);
        match_t      best;
        int unsigned span;
        int unsigned d;
        span = shadow_count;
        if (span > npcm_pkg::PALETTE_DEPTH)
            span = npcm_pkg::PALETTE_DEPTH;
        if (span > 256)
            span = 256;
        best.color   = pixel;
        best.index   = '0;
        best.sq_dist = '0;
        best.hit     = 1'b0;
        for (int unsigned i = 0; i < span; i++)
        begin
            d = rgba_distance(pixel, shadow_palette[i]);
            if (!best.hit || d < best.sq_dist)
            begin
                best.hit     = 1'b1;
                best.sq_dist = d[npcm_pkg::DIST_W-1:0];
                best.color   = shadow_palette[i];
                best.index   = i[7:0];
            end
        end
        return best;
    endfunction

    // Color with channels often pinned at 0x00 or 0xFF
    function automatic logic [npcm_pkg::COLOR_W-1:0] rand_color();
        logic [npcm_pkg::COLOR_W-1:0] c;
        int unsigned                  pick;
        c = $urandom;
        for (int ch = 0; ch < npcm_pkg::NUM_CHAN; ch++)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                c[ch*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] = 8'h00;
            else if (pick == 1)
                c[ch*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] = 8'hFF;
        end
        return c;
    endfunction

    // Color a few steps away from base on every channel, clamped
    function automatic logic [npcm_pkg::COLOR_W-1:0] near_color(
        input logic [npcm_pkg::COLOR_W-1:0] base);
        logic [npcm_pkg::COLOR_W-1:0] c;
        int                           v;
        for (int ch = 0; ch < npcm_pkg::NUM_CHAN; ch++)
        begin
            v = int'(base[ch*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W])
              + int'($urandom_range(0, 6)) - 3;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            c[ch*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] = v[7:0];
        end
        return c;
    endfunction

    function automatic string fmt_match(input match_t m);
        return $sformatf("color=%h idx=%0d dist=%0d hit=%0b",
                         m.color, m.index, m.sq_dist, m.hit);
    endfunction

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // Driver: presents queued items, predicts each transfer as it happens
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            operation   <= npcm_pkg::OP_LOAD;
            entry_index <= '0;
            pixel_color <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_items++;
                if (operation == npcm_pkg::OP_LOAD)
                begin
                    loads_taken++;
                    if (entry_index < npcm_pkg::PALETTE_DEPTH)
                        shadow_palette[entry_index] = pixel_color;
                end
                else
                begin
                    maps_taken++;
                    expected_matches = {expected_matches, nearest_entry(pixel_color)};
                end
            end

            if (in_valid && !in_ready)
            begin
                // hold the item until its transfer
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_items.size() > 0 && $urandom_range(0, 99) >= send_odds)
            begin
                next_item   = pixel_items.pop_front();
                operation   <= next_item.op;
                entry_index <= next_item.slot;
                pixel_color <= next_item.color;
                in_valid    <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
                if (pixel_items.size() > 0)
                    send_gap <= $urandom_range(0, 10);
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = {mapped_color, match_index, match_distance, matched};
                if (expected_matches.size() == 0)
                    log_failure($sformatf("unexpected result: %s", fmt_match(got)));
                else
                begin
                    want = expected_matches.pop_front();
                    if (got.color !== want.color || got.index !== want.index ||
                        got.sq_dist !== want.sq_dist || got.hit !== want.hit)
                        log_failure($sformatf("mismatch: want %s, got %s",
                                              fmt_match(want), fmt_match(got)));
                end
            end

            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_odds)
            begin
                recv_gap  <= $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
                $display("[nearest_palette_color_mapper_top] ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(input logic op, input int unsigned slot,
                             input logic [npcm_pkg::COLOR_W-1:0] color);
        pixel_item_t it;
        it.op    = op;
        it.slot  = slot[npcm_pkg::ADDR_W-1:0];
        it.color = color;
        pixel_items = {pixel_items, it};
        pushed_items++;
        if (op == npcm_pkg::OP_LOAD)
            gen_palette[slot[npcm_pkg::ADDR_W-1:0]] = color;
    endtask

    // Let every item transfer and every result arrive, then let the scan settle
    task automatic drain_block();
        while (accepted_items != pushed_items || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input int unsigned value);
        drain_block();
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value[npcm_pkg::COUNT_W-1:0];
        shadow_count = value & ((1 << npcm_pkg::COUNT_W) - 1);
        @(posedge clk);
        cfg_we <= 1'b0;
        count_writes++;
    endtask

    // One random phase: loads mixed with maps, tuned to the active span
    task automatic random_phase(input int unsigned count);
        int unsigned span;
        int unsigned n;
        int unsigned r;
        int unsigned slot;
        logic [npcm_pkg::COLOR_W-1:0] base;
        span = (count > 256) ? 256 : count;
        n    = (count > 64) ? $urandom_range(8, 16) : $urandom_range(15, 40);
        for (int unsigned k = 0; k < n; k++)
        begin
            r    = $urandom_range(0, 99);
            slot = (span > 0) ? $urandom_range(0, span - 1) : 0;
            base = gen_palette[slot];
            if (r < 35)
            begin
                if (r < 28 && span > 0)
                    push_item(npcm_pkg::OP_LOAD, slot,
                              (r < 7) ? gen_palette[$urandom_range(0, 255)] : rand_color());
                else
                    push_item(npcm_pkg::OP_LOAD, $urandom_range(0, 255), rand_color());
            end
            else if (r < 50)
                push_item(npcm_pkg::OP_MAP, $urandom_range(0, 255), base);
            else if (r < 70)
                push_item(npcm_pkg::OP_MAP, $urandom_range(0, 255), near_color(base));
            else if (r < 85)
                push_item(npcm_pkg::OP_MAP, $urandom_range(0, 255), rand_color());
            else
                push_item(npcm_pkg::OP_MAP, $urandom_range(0, 255), $urandom);
        end
    endtask

    // Sequencer: reset, directed cases, palette fill, random phases, end of run
    initial
    begin
        int unsigned count;
        int unsigned r;
        int unsigned odds_pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty palette: pixel passes through unmatched
        set_count(0);
        push_item(npcm_pkg::OP_MAP, 0, 32'h0000_0000);
        push_item(npcm_pkg::OP_MAP, 255, 32'hFFFF_FFFF);

        // Small palette with a duplicate entry for the tie rule
        push_item(npcm_pkg::OP_LOAD, 0, 32'h0000_0000);
        push_item(npcm_pkg::OP_LOAD, 1, 32'hFFFF_FFFF);
        push_item(npcm_pkg::OP_LOAD, 2, 32'hFFFF_FFFF);
        push_item(npcm_pkg::OP_LOAD, 3, 32'h8080_8080);
        push_item(npcm_pkg::OP_LOAD, 255, 32'h1234_5678);
        set_count(4);
        push_item(npcm_pkg::OP_MAP, 0, 32'hFFFF_FFFF);
        push_item(npcm_pkg::OP_MAP, 0, 32'h0000_0000);
        push_item(npcm_pkg::OP_MAP, 0, 32'h7F7F_7F7F);
        push_item(npcm_pkg::OP_MAP, 0, 32'h4040_4040);
        push_item(npcm_pkg::OP_MAP, 0, 32'hFF00_FF00);
        push_item(npcm_pkg::OP_MAP, 0, 32'h00FF_00FF);

        // Largest possible distance
        set_count(1);
        push_item(npcm_pkg::OP_MAP, 0, 32'hFFFF_FFFF);

        // Fill every slot so any span is legal from here on
        recv_odds = 20;
        send_odds = 10;
        for (int unsigned s = 0; s < npcm_pkg::PALETTE_DEPTH; s++)
            push_item(npcm_pkg::OP_LOAD, s, rand_color());

        // Count beyond the depth saturates to the full palette
        set_count(511);
        push_item(npcm_pkg::OP_MAP, 0, rand_color());
        push_item(npcm_pkg::OP_MAP, 0, gen_palette[255]);
        set_count(256);
        push_item(npcm_pkg::OP_MAP, 0, rand_color());
        push_item(npcm_pkg::OP_MAP, 0, gen_palette[0]);

        // Random phases, mostly small spans
        while (pushed_items < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                count = 0;
            else if (r < 10)
                count = $urandom_range(256, 511);
            else if (r < 22)
                count = $urandom_range(17, 64);
            else
                count = $urandom_range(1, 16);
            set_count(count);
            if (pushed_items >= CALM_ITEMS)
            begin
                send_odds = 0;
                recv_odds = 0;
            end
            else
            begin
                odds_pick = $urandom_range(0, 3);
                send_odds = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 10 : 35;
                odds_pick = $urandom_range(0, 3);
                recv_odds = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 10 : 35;
            end
            random_phase(count);
        end

        drain_block();
        if (expected_matches.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_matches.size());
            failures += expected_matches.size();
        end

        $display("covered %0d transfers in (%0d loads, %0d maps), %0d results checked,",
                 accepted_items, loads_taken, maps_taken, results_seen);
        $display("%0d palette_count writes from empty to beyond full, %0d failures",
                 count_writes, failures);
        if (failures == 0)
            $display("[nearest_palette_color_mapper_top] OK");
        else
            $display("[nearest_palette_color_mapper_top] ERROR");
        $finish;
    end

endmodule
